@@ sv/median5_spike_fill_filter_core_macros.svh @@
// Assertion macros shared by the median spike fill filter RTL.
// Both macros expect a clock named clk_i in scope; M5SF_ASSERT also expects an active-low reset named rst_ni.
`ifndef MEDIAN5_SPIKE_FILL_FILTER_CORE_MACROS_SVH
`define MEDIAN5_SPIKE_FILL_FILTER_CORE_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define M5SF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define M5SF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ sv/m5sf_pkg.sv @@
// Package for the five-tap median spike fill filter: payload types, widths and constants.
// It depends on nothing else; the top level imports it.
`default_nettype none

package m5sf_pkg;

  // Sample format and window size.
  localparam int unsigned SAMPLE_BITS    = 32;
  localparam int unsigned WINDOW_TAPS    = 5;
  localparam int unsigned MEDIAN_RANK    = 2;
  localparam int unsigned RANK_W         = 3;

  // Row position counter saturates at the longest row.
  localparam int unsigned MAX_ROW_LENGTH = 1024;
  localparam int unsigned POS_W          = 11;

  // Spike threshold register.
  localparam int unsigned THR_W          = 31;
  localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(2560);

  // APB register map: register index sits at paddr[2].
  localparam int unsigned PADDR_W        = 3;
  localparam int unsigned PDATA_W        = 32;
  localparam logic REG_SPIKE_THRESHOLD   = 1'b0;

  // Result queue: room for one item's worst case of three results plus one.
  localparam int unsigned MAX_RESULTS    = 3;
  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam int unsigned Q_CNT_W        = 3;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t sample_value;
    logic    row_end;
  } in_item_t;

  typedef struct packed {
    sample_t filtered_value;
    logic    row_last;
  } out_item_t;

endpackage : m5sf_pkg

`default_nettype wire

@@ sv/median5_spike_fill_filter_core.sv @@
// Five-tap median spike fill filter along an image row, with an APB threshold register.
// Depends on m5sf_pkg and on median5_spike_fill_filter_core_macros.svh.
//
//   Channel  Direction  Handshake                  Payload
//   in       in         in_valid_i / in_stall_o    in_data_i  (sample_value, row_end)
//   out      out        out_valid_o / out_stall_i  out_data_o (filtered_value, row_last)
//   apb      in         psel, penable, pready      paddr, pwdata, prdata
//
// One sample is taken per cycle while in_stall_o is low. A sample enters the window register on
// its transfer; once the queue has room, the median network places its results in a four-entry
// result queue, from which the output takes them. A row end yields up to three results, which the
// queue drains one per cycle while the output does not stall; input stalls while the queue lacks
// room for three results.
// Reset clears the window, the row position and the queue count, and sets the threshold to 2560.
`default_nettype none

`include "median5_spike_fill_filter_core_macros.svh"

module median5_spike_fill_filter_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Sample input
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire m5sf_pkg::in_item_t           in_data_i,
  // Result output
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output m5sf_pkg::out_item_t               out_data_o,
  // Configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [m5sf_pkg::PADDR_W-1:0] paddr,
  input  wire logic [m5sf_pkg::PDATA_W-1:0] pwdata,
  output logic      [m5sf_pkg::PDATA_W-1:0] prdata,
  output logic                              pready
);
  import m5sf_pkg::*;

  logic [THR_W-1:0]     thr_q;
  sample_t              window_q [WINDOW_TAPS];
  logic [POS_W-1:0]     pos_q, pos_d, pos_n;
  logic                 s1_valid_q, s1_valid_d;
  logic                 s1_end_q, s1_ge2_q, s1_ge3_q, s1_ge5_q;
  out_item_t            queue_q [QUEUE_DEPTH];
  out_item_t            queue_d [QUEUE_DEPTH];
  logic [Q_CNT_W-1:0]   q_cnt_q, q_cnt_d, cnt_pop;
  logic                 in_acc, pop, s1_adv;
  logic [RANK_W-1:0]    rank [WINDOW_TAPS];
  sample_t              median, center;
  logic [SAMPLE_BITS:0] diff;
  logic                 fill;
  out_item_t            push [MAX_RESULTS];
  logic [Q_CNT_W-1:0]   push_n;

  // APB register access; a write completes in the access phase.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_SPIKE_THRESHOLD)) begin
      thr_q <= pwdata[THR_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_SPIKE_THRESHOLD) begin
      prdata = PDATA_W'(thr_q);
    end
  end

  // Handshakes. The window stage moves on when the queue has room for three results.
  assign out_valid_o = (q_cnt_q != '0);
  assign out_data_o  = queue_q[0];
  assign pop         = out_valid_o && !out_stall_i;
  assign cnt_pop     = q_cnt_q - Q_CNT_W'(pop);
  assign s1_adv      = s1_valid_q && (cnt_pop <= Q_CNT_W'(QUEUE_DEPTH - MAX_RESULTS));
  assign in_stall_o  = s1_valid_q && !s1_adv;
  assign in_acc      = in_valid_i && !in_stall_o;

  // Row position, saturating at the longest row length.
  always_comb begin
    pos_n = pos_q + POS_W'(1);
    if (pos_n > POS_W'(MAX_ROW_LENGTH)) begin
      pos_n = POS_W'(MAX_ROW_LENGTH);
    end
    pos_d = in_data_i.row_end ? '0 : pos_n;
  end

  assign s1_valid_d = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);

  // Window stage: shift the new sample in and note how far into the row it lies.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_TAPS; i++) begin
        window_q[i] <= '0;
      end
      pos_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_end_q   <= 1'b0;
      s1_ge2_q   <= 1'b0;
      s1_ge3_q   <= 1'b0;
      s1_ge5_q   <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (in_acc) begin
        for (int i = 0; i < WINDOW_TAPS - 1; i++) begin
          window_q[i] <= window_q[i+1];
        end
        window_q[WINDOW_TAPS-1] <= in_data_i.sample_value;
        pos_q    <= pos_d;
        s1_end_q <= in_data_i.row_end;
        s1_ge2_q <= (pos_n >= POS_W'(2));
        s1_ge3_q <= (pos_n >= POS_W'(3));
        s1_ge5_q <= (pos_n >= POS_W'(5));
      end
    end
  end

  // Median by rank: ties are broken by window position, so exactly one tap has rank two.
  always_comb begin
    median = '0;
    for (int i = 0; i < WINDOW_TAPS; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WINDOW_TAPS; j++) begin
        if (j != i) begin
          if ((window_q[j] < window_q[i]) || ((window_q[j] == window_q[i]) && (j < i))) begin
            rank[i] = rank[i] + RANK_W'(1);
          end
        end
      end
      if (rank[i] == RANK_W'(MEDIAN_RANK)) begin
        median = median | window_q[i];
      end
    end
  end

  // Spike test on the centre tap: with a full window, the median must exceed it by more than the threshold.
  assign center = window_q[2];
  assign diff   = {median[SAMPLE_BITS-1], median} - {center[SAMPLE_BITS-1], center};
  assign fill   = s1_ge5_q && (median > center) &&
                  (diff > (SAMPLE_BITS+1)'(thr_q));

  // Results of the item in the window stage, in output order.
  always_comb begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      push[k] = '{filtered_value: window_q[WINDOW_TAPS-1], row_last: 1'b1};
    end
    push_n = '0;
    if (s1_ge3_q) begin
      push[0] = '{filtered_value: (fill ? median : center), row_last: 1'b0};
      push_n  = Q_CNT_W'(1);
    end
    if (s1_end_q) begin
      if (s1_ge2_q) begin
        push[push_n[1:0]]        = '{filtered_value: window_q[WINDOW_TAPS-2], row_last: 1'b0};
        push[push_n[1:0] + 2'd1] = '{filtered_value: window_q[WINDOW_TAPS-1], row_last: 1'b1};
        push_n = push_n + Q_CNT_W'(2);
      end else begin
        push[push_n[1:0]] = '{filtered_value: window_q[WINDOW_TAPS-1], row_last: 1'b1};
        push_n = push_n + Q_CNT_W'(1);
      end
    end
  end

  // Result queue: the head sits in entry zero and moves up on each output transfer.
  always_comb begin
    for (int e = 0; e < QUEUE_DEPTH; e++) begin
      if (pop && (e < QUEUE_DEPTH - 1)) begin
        queue_d[e] = queue_q[e+1];
      end else begin
        queue_d[e] = queue_q[e];
      end
      for (int k = 0; k < MAX_RESULTS; k++) begin
        if (s1_adv && (Q_CNT_W'(k) < push_n) && ((cnt_pop + Q_CNT_W'(k)) == Q_CNT_W'(e))) begin
          queue_d[e] = push[k];
        end
      end
    end
    q_cnt_d = cnt_pop + (s1_adv ? push_n : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_cnt_q <= '0;
    end else begin
      q_cnt_q <= q_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int e = 0; e < QUEUE_DEPTH; e++) begin
      queue_q[e] <= queue_d[e];
    end
  end

  // Checks on the queue and row tracking.
  `M5SF_ASSERT(a_queue_bound, q_cnt_q <= Q_CNT_W'(QUEUE_DEPTH), "result queue overfilled")
  `M5SF_ASSERT(a_adv_room, s1_adv |-> (cnt_pop + push_n) <= Q_CNT_W'(QUEUE_DEPTH), "no room")
  `M5SF_ASSERT(a_row_restart, (in_acc && in_data_i.row_end) |=> (pos_q == '0), "row not reset")
  `M5SF_ASSERT(a_pos_bound, pos_q <= POS_W'(MAX_ROW_LENGTH), "row position overrun")
  `M5SF_ASSERT_ALWAYS(a_pready_high, pready, "pready low")

endmodule : median5_spike_fill_filter_core

`default_nettype wire

@@ verif/tb_median5_spike_fill_filter_core.sv @@
// Self-checking testbench for the five-tap median spike fill filter core.
// Depends on m5sf_pkg and the RTL of median5_spike_fill_filter_core, which includes the macros header.
// A row-window predictor forms the expected results, which are checked against every transfer out.
`default_nettype none

module tb_median5_spike_fill_filter_core;
  timeunit 1ns;
  timeprecision 1ps;

  import m5sf_pkg::*;

  localparam int unsigned LONG_HOLD_CYCLES = 120;
  localparam int unsigned WATCHDOG_LIMIT   = 3000;
  localparam int unsigned SETTLE_CYCLES    = 6;
  localparam logic [PADDR_W-1:0] THRESHOLD_ADDR = {REG_SPIKE_THRESHOLD, 2'b00};
  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Clock, reset and the block's ports; reset and the driven inputs start at known values.
  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_item_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_data_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [PADDR_W-1:0]  paddr       = '0;
  logic [PDATA_W-1:0]  pwdata      = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  // Predictor state: its own copy of the row window, row position and threshold.
  sample_t             window_taps [WINDOW_TAPS];
  int unsigned         row_count   = 0;
  logic [THR_W-1:0]    spike_limit = THRESHOLD_RESET;

  in_item_t            pending_items[$];
  out_item_t           expected_results[$];
  int unsigned         error_count = 0;
  int unsigned         send_gap = 0;
  int unsigned         hold_left = 0;
  int unsigned         idle_cycles = 0;
  logic                full_rate = 1'b0;
  logic                long_hold_req = 1'b0;
  logic                long_hold_taken = 1'b0;

  median5_spike_fill_filter_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    for (int i = 0; i < WINDOW_TAPS; i++) window_taps[i] = '0;
  end

  task automatic report_error(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Gap lengths: mostly none, often short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic sample_t window_median();
    sample_t sorted [WINDOW_TAPS];
    sample_t swap;
    for (int i = 0; i < WINDOW_TAPS; i++) sorted[i] = window_taps[i];
    for (int i = 0; i < WINDOW_TAPS - 1; i++) begin
      for (int j = 0; j < WINDOW_TAPS - 1 - i; j++) begin
        if (sorted[j] > sorted[j+1]) begin
          swap        = sorted[j];
          sorted[j]   = sorted[j+1];
          sorted[j+1] = swap;
        end
      end
    end
    return sorted[MEDIAN_RANK];
  endfunction

  // Appends one predicted result at the tail of the expected results.
  function automatic void add_expected(sample_t value, logic last);
    expected_results.insert(expected_results.size(),
                            out_item_t'{filtered_value: value, row_last: last});
  endfunction

  // Shifts one sample into the window and queues the results it releases.
  task automatic predict_transfer(in_item_t item);
    int unsigned taken;
    sample_t     centre;
    sample_t     med;
    for (int i = 0; i < WINDOW_TAPS - 1; i++) window_taps[i] = window_taps[i+1];
    window_taps[WINDOW_TAPS-1] = item.sample_value;
    taken = (row_count >= MAX_ROW_LENGTH) ? MAX_ROW_LENGTH : row_count + 1;

    // The window centre is emitted once three samples are in; filled only with a full window.
    if (taken >= 3) begin
      centre = window_taps[MEDIAN_RANK];
      if (taken >= WINDOW_TAPS) begin
        med = window_median();
        if (med > centre && (longint'(med) - longint'(centre)) > longint'(spike_limit))
          centre = med;
      end
      add_expected(centre, 1'b0);
    end

    // A row end flushes the newer samples still held, unchanged.
    if (item.row_end) begin
      if (taken >= 2)
        add_expected(window_taps[WINDOW_TAPS-2], 1'b0);
      add_expected(window_taps[WINDOW_TAPS-1], 1'b1);
      row_count = 0;
    end else begin
      row_count = taken;
    end
  endtask

  // Sender: presents queued samples with random gaps, none at full rate, and predicts on each transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) predict_transfer(in_data_i);
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap != 0) begin
          in_valid_i <= 1'b0;
          send_gap   <= send_gap - 1;
        end else if (pending_items.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_items.pop_front();
          send_gap   <= full_rate ? 0 : pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result transfer and drives random stalls, one long hold-off included, except at full rate.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_error($sformatf("unexpected result value %0d last %0b",
                                 out_data_o.filtered_value, out_data_o.row_last));
        end else begin
          want = expected_results.pop_front();
          if (out_data_o.filtered_value !== want.filtered_value)
            report_error($sformatf("filtered_value %0d, predicted %0d",
                                   out_data_o.filtered_value, want.filtered_value));
          if (out_data_o.row_last !== want.row_last)
            report_error($sformatf("row_last %0b, predicted %0b",
                                   out_data_o.row_last, want.row_last));
        end
      end

      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left   <= hold_left - 1;
      end else if (long_hold_req && !long_hold_taken) begin
        long_hold_taken <= 1'b1;
        out_stall_i     <= 1'b1;
        hold_left       <= LONG_HOLD_CYCLES;
      end else if (full_rate) begin
        out_stall_i <= 1'b0;
      end else begin
        hold_left   <= pick_gap();
        out_stall_i <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  // Watchdog: ends the run after a long stretch without any transfer.
  always @(posedge clk_i) begin
    if (!rst_ni || psel || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic in_item_t make_item(sample_t value, logic last);
    return in_item_t'{sample_value: value, row_end: last};
  endfunction

  // Appends one sample at the tail of the pending items.
  function automatic void queue_item(sample_t value, logic last);
    pending_items.insert(pending_items.size(), make_item(value, last));
  endfunction

  // Row content: mostly noise around a base level, with dark spikes, bright spikes and extremes.
  function automatic sample_t row_sample(sample_t base);
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return sample_t'($urandom);
    if (roll == 1) return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
    if (roll < 5) return base - sample_t'($urandom_range(1000, 60000));
    if (roll == 5) return base + sample_t'($urandom_range(1000, 60000));
    return base + sample_t'($urandom_range(0, 8000)) - sample_t'(4000);
  endfunction

  task automatic queue_row(int unsigned len);
    sample_t base;
    base = sample_t'($urandom_range(0, 2097152)) - sample_t'(1048576);
    for (int unsigned k = 0; k < len; k++)
      queue_item(row_sample(base), k == len - 1);
  endtask

  // Rows are mostly short so that row starts and ends come often.
  task automatic queue_rows(int unsigned budget, int unsigned max_len);
    int unsigned left;
    int unsigned len;
    left = budget;
    while (left != 0) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, max_len) : $urandom_range(1, 12);
      if (len > left) len = left;
      queue_row(len);
      left -= len;
    end
  endtask

  // Waits until every queued sample has gone in and every predicted result has come out.
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Threshold write followed by a read back, back to back on the configuration port.
  task automatic write_spike_limit(logic [THR_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= THRESHOLD_ADDR;
    pwdata  <= PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    spike_limit = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[THR_W-1:0] !== value)
      report_error($sformatf("threshold read back %0d, written %0d", prdata[THR_W-1:0], value));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows at the reset threshold: short rows, the exact threshold edge and extremes.
    queue_item(SAMPLE_MAX, 1'b1);
    queue_item(SAMPLE_MIN, 1'b0);
    queue_item(-1, 1'b1);
    queue_item(100, 1'b0);
    queue_item(-100, 1'b0);
    queue_item(7, 1'b1);
    queue_item(256, 1'b0);
    queue_item(-300000, 1'b0);
    queue_item(256, 1'b0);
    queue_item(256, 1'b1);
    queue_item(0, 1'b0);
    queue_item(0, 1'b0);
    queue_item(-2560, 1'b0);
    queue_item(0, 1'b0);
    queue_item(-2561, 1'b0);
    queue_item(0, 1'b0);
    queue_item(5000, 1'b0);
    queue_item(0, 1'b1);
    queue_item(SAMPLE_MAX, 1'b0);
    queue_item(SAMPLE_MAX, 1'b0);
    queue_item(SAMPLE_MIN, 1'b0);
    queue_item(SAMPLE_MAX, 1'b0);
    queue_item(SAMPLE_MAX, 1'b1);
    wait_drained();

    // Zero threshold: every centre tap of a full window that dips below the median is filled.
    write_spike_limit('0);
    queue_rows(100, 40);
    wait_drained();

    // Largest threshold, run without any idling on either side.
    write_spike_limit({THR_W{1'b1}});
    full_rate <= 1'b1;
    queue_rows(80, 30);
    wait_drained();
    full_rate <= 1'b0;

    // Random threshold; the receiver holds off long enough for the input to stall.
    write_spike_limit(THR_W'($urandom_range(0, 20000)));
    queue_rows(150, 40);
    long_hold_req <= 1'b1;
    wait_drained();

    // Back to the reset value, with some longer rows.
    write_spike_limit(THRESHOLD_RESET);
    queue_rows(110, 60);
    wait_drained();

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule : tb_median5_spike_fill_filter_core

`default_nettype wire
